>>> rtl/core/text_blank_line_trimmer_core_defines.svh
// Assertion macros for the text blank line trimmer core.
`ifndef TEXT_BLANK_LINE_TRIMMER_CORE_DEFINES_SVH
`define TEXT_BLANK_LINE_TRIMMER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBLT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBLT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tblt_pkg.sv
// Shared types, constants and byte classification for the blank line trimmer.
package tblt_pkg;

	localparam int MAX_WS_RUN = 63;
	localparam int CNT_W      = 6;
	localparam int IDX_W      = 6;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef logic [1:0] cls_t;
	localparam cls_t CLS_DROP = 2'd0;
	localparam cls_t CLS_LF   = 2'd1;
	localparam cls_t CLS_WS   = 2'd2;
	localparam cls_t CLS_VIS  = 2'd3;

	typedef logic [1:0] osel_t;
	localparam osel_t OSEL_LF   = 2'd0;
	localparam osel_t OSEL_WS   = 2'd1;
	localparam osel_t OSEL_BYTE = 2'd2;
	localparam osel_t OSEL_IN   = 2'd3;

	typedef struct packed {
		logic  byte_ld;
		logic  push;
		logic  set_ovf;
		logic  set_skip;
		logic  clr_skip;
		logic  cnt_clr;
		logic  idx_clr;
		logic  idx_inc;
		logic  ld_out;
		osel_t out_sel;
		logic  out_last;
	} cmd_t;

	typedef struct packed {
		cls_t cls;
		logic skip;
		logic cnt_zero;
		logic cnt_full;
		logic idx_last;
		logic out_free;
	} sts_t;

	function automatic cls_t classify(input logic [7:0] b, input logic drop);
		cls_t c;
		if (b < CH_SPACE && b != CH_TAB && b != CH_LF && drop) begin
			c = CLS_DROP;
		end else if (b == CH_LF) begin
			c = CLS_LF;
		end else if (b == CH_SPACE || b == CH_TAB) begin
			c = CLS_WS;
		end else begin
			c = CLS_VIS;
		end
		return c;
	endfunction

endpackage

>>> rtl/core/tblt_dp.sv
// Datapath: whitespace run buffer, counters, mode flags and output register.
module tblt_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic [7:0]         s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast,
	output logic               m_tuser,
	input  tblt_pkg::cmd_t     cmd,
	output tblt_pkg::sts_t     sts
);

	logic                       drop_q;
	logic                       skip_q;
	logic                       ovf_q;
	logic [tblt_pkg::CNT_W-1:0] cnt_q;
	logic [tblt_pkg::IDX_W-1:0] idx_q;
	logic [tblt_pkg::IDX_W-1:0] idx_d;
	logic                       kind_mem [0:tblt_pkg::MAX_WS_RUN-1];
	logic                       rd_q;
	logic [7:0]                 byte_q;
	logic                       vld_q;
	logic [7:0]                 data_q;
	logic                       last_q;
	logic                       user_q;
	logic [7:0]                 out_mux;

	always_comb begin
		if (cmd.idx_clr) begin
			idx_d = '0;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + 1'b1;
		end else begin
			idx_d = idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b1;
			skip_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			idx_q  <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				drop_q <= cfg_wdata;
			end
			if (cmd.set_skip) begin
				skip_q <= 1'b1;
			end else if (cmd.clr_skip) begin
				skip_q <= 1'b0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.push) begin
				cnt_q <= cnt_q + 1'b1;
			end
			idx_q <= idx_d;
			if (cmd.ld_out) begin
				vld_q <= 1'b1;
			end else if (m_tready) begin
				vld_q <= 1'b0;
			end
		end
	end

	// run buffer: one write port at the fill count, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			kind_mem[cnt_q] <= (s_tdata == tblt_pkg::CH_TAB);
		end
		rd_q <= kind_mem[idx_d];
	end

	always_comb begin
		case (cmd.out_sel)
			tblt_pkg::OSEL_LF:   out_mux = tblt_pkg::CH_LF;
			tblt_pkg::OSEL_WS:   out_mux = rd_q ? tblt_pkg::CH_TAB : tblt_pkg::CH_SPACE;
			tblt_pkg::OSEL_BYTE: out_mux = byte_q;
			tblt_pkg::OSEL_IN:   out_mux = s_tdata;
			default:             out_mux = s_tdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_ld) begin
			byte_q <= s_tdata;
		end
		if (cmd.ld_out) begin
			data_q <= out_mux;
			last_q <= cmd.out_last;
			user_q <= ovf_q;
		end
	end

	assign sts.cls      = tblt_pkg::classify(s_tdata, drop_q);
	assign sts.skip     = skip_q;
	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.cnt_full = (cnt_q == tblt_pkg::CNT_W'(tblt_pkg::MAX_WS_RUN));
	assign sts.idx_last = (idx_q == cnt_q - 1'b1);
	assign sts.out_free = !vld_q || m_tready;

	assign m_tvalid = vld_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = user_q;

endmodule

>>> rtl/core/tblt_ctrl.sv
// Controller: sequences intake, line feed, buffered whitespace and the visible byte.
module tblt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  tblt_pkg::sts_t sts,
	output tblt_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LF   = 2'd1;
	localparam logic [1:0] ST_WS   = 2'd2;
	localparam logic [1:0] ST_BYTE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (sts.cls)
						tblt_pkg::CLS_LF: begin
							cmd.cnt_clr  = 1'b1;
							cmd.set_skip = 1'b1;
						end
						tblt_pkg::CLS_WS: begin
							if (!sts.skip) begin
								cmd.push    = !sts.cnt_full;
								cmd.set_ovf = sts.cnt_full;
							end
						end
						tblt_pkg::CLS_VIS: begin
							cmd.byte_ld = 1'b1;
							cmd.idx_clr = 1'b1;
							if (sts.skip) begin
								state_d = ST_LF;
							end else if (!sts.cnt_zero) begin
								state_d = ST_WS;
							end else if (sts.out_free) begin
								cmd.ld_out   = 1'b1;
								cmd.out_sel  = tblt_pkg::OSEL_IN;
								cmd.out_last = 1'b1;
							end else begin
								state_d = ST_BYTE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_LF: begin
				if (sts.out_free) begin
					cmd.ld_out   = 1'b1;
					cmd.out_sel  = tblt_pkg::OSEL_LF;
					cmd.clr_skip = 1'b1;
					cmd.idx_clr  = 1'b1;
					state_d      = sts.cnt_zero ? ST_BYTE : ST_WS;
				end
			end
			ST_WS: begin
				if (sts.out_free) begin
					cmd.ld_out  = 1'b1;
					cmd.out_sel = tblt_pkg::OSEL_WS;
					if (sts.idx_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_BYTE;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_BYTE: begin
				if (sts.out_free) begin
					cmd.ld_out   = 1'b1;
					cmd.out_sel  = tblt_pkg::OSEL_BYTE;
					cmd.out_last = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/text_blank_line_trimmer_core.sv
// Top level of the text blank line trimmer: controller plus datapath.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata[7:0] = in_byte
//   m_*      out  m_tvalid/m_tready  m_tdata = out_byte, m_tlast, m_tuser
//   cfg_*    in   cfg_we             cfg_wdata = drop_controls
//
// Whitespace, line feed and dropped bytes are taken in the idle state. A visible
// byte with nothing buffered is loaded into the output register when it is taken.
// Otherwise the pending line feed, buffered run and byte follow, one output word
// per cycle while m_tready is high, from the single read port of the run buffer.
// The output register stalls the sequence while m_tready is low.
// Reset sets drop_controls and clears mode, count and overflow flag.
module text_blank_line_trimmer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic       m_tuser    // [0] run_overflowed
);

	tblt_pkg::cmd_t cmd;
	tblt_pkg::sts_t sts;

	tblt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tblt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

>>> rtl/core/tblt_checker.sv
// Port-level checker for the text blank line trimmer, bound to the top level.
`include "text_blank_line_trimmer_core_defines.svh"

module tblt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic       m_tuser
);

	logic       m_stall;
	logic [9:0] m_word;
	logic       m_is_ws;

	assign m_stall = m_tvalid && !m_tready;
	assign m_word  = {m_tuser, m_tlast, m_tdata};
	assign m_is_ws = m_tdata inside {tblt_pkg::CH_LF, tblt_pkg::CH_SPACE, tblt_pkg::CH_TAB};

	`TBLT_ASSERT_NXT(a_stall_hold, clk, arst_n, m_stall, m_tvalid && $stable(m_word), "word not held")
	`TBLT_ASSERT_NXT(a_ovf_sticky, clk, arst_n, m_tvalid && m_tuser, !m_tvalid || m_tuser, "flag cleared")
	`TBLT_ASSERT_IMP(a_mid_is_ws, clk, arst_n, m_tvalid && !m_tlast, m_is_ws, "inner word visible")
	`TBLT_ASSERT_IMP(a_last_vis, clk, arst_n, m_tvalid && m_tlast, !m_is_ws, "final word is whitespace")

endmodule

bind text_blank_line_trimmer_core tblt_checker u_tblt_checker (.*);

>>> verif/tb.sv
// Testbench for text_blank_line_trimmer_core: queued text stimulus, inline trim predictor, word checker.
module tb;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int LONG_RUN_LEN   = 66;

	typedef enum int {IDLE_TX_LIGHT, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
		logic       ovf;
	} text_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	text_blank_line_trimmer_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic       drop_ctl = 1'b1;
	logic       in_gap = 1'b0;
	logic       ws_tab [tblt_pkg::MAX_WS_RUN];
	int         ws_len = 0;
	logic       ovf_seen = 1'b0;

	logic [7:0] text_bytes [$];
	text_word_t clean_words [$];
	idle_mode_t idle_mode = IDLE_TX_LIGHT;
	int         errors = 0;
	logic       rx_hold_req = 1'b0;
	logic       rx_hold_done = 1'b0;
	int         rx_hold_left = 0;
	int         quiet_cycles = 0;

	function automatic void push_clean(logic [7:0] b, logic last);
		text_word_t w;
		w.data = b;
		w.last = last;
		w.ovf  = ovf_seen;
		clean_words.push_back(w);
	endfunction

	function automatic void trim_predict(logic [7:0] b);
		int k;
		if (b < tblt_pkg::CH_SPACE && b != tblt_pkg::CH_TAB && b != tblt_pkg::CH_LF && drop_ctl)
			return;
		if (b == tblt_pkg::CH_LF) begin
			ws_len = 0;
			in_gap = 1'b1;
			return;
		end
		if (b == tblt_pkg::CH_SPACE || b == tblt_pkg::CH_TAB) begin
			if (in_gap)
				return;
			if (ws_len < tblt_pkg::MAX_WS_RUN) begin
				ws_tab[ws_len] = (b == tblt_pkg::CH_TAB);
				ws_len++;
			end else begin
				ovf_seen = 1'b1;
			end
			return;
		end
		if (in_gap) begin
			push_clean(tblt_pkg::CH_LF, 1'b0);
			in_gap = 1'b0;
		end
		for (k = 0; k < ws_len; k++)
			push_clean(ws_tab[k] ? tblt_pkg::CH_TAB : tblt_pkg::CH_SPACE, 1'b0);
		ws_len = 0;
		push_clean(b, 1'b1);
	endfunction

	function automatic logic tx_idles();
		case (idle_mode)
			IDLE_TX_LIGHT: return $urandom_range(0, 99) < 32;
			IDLE_TX_HEAVY: return $urandom_range(0, 99) < 59;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic logic rx_idles();
		case (idle_mode)
			IDLE_TX_LIGHT: return $urandom_range(0, 99) < 59;
			IDLE_TX_HEAVY: return $urandom_range(0, 99) < 32;
			default:       return 1'b0;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				trim_predict(s_tdata);
				void'(text_bytes.pop_front());
			end
			if (s_tvalid && !s_tready) begin
				s_tvalid <= 1'b1;
			end else if (text_bytes.size() == 0 || tx_idles()) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= text_bytes[0];
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		text_word_t w;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (clean_words.size() == 0) begin
					$display("%0t unexpected word %h last %b ovf %b", $time,
						m_tdata, m_tlast, m_tuser);
					errors++;
				end else begin
					w = clean_words.pop_front();
					if (m_tdata !== w.data || m_tlast !== w.last || m_tuser !== w.ovf) begin
						$display("%0t expected %h last %b ovf %b, got %h last %b ovf %b",
							$time, w.data, w.last, w.ovf, m_tdata, m_tlast, m_tuser);
						errors++;
					end
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left <= rx_hold_left - 1;
				m_tready <= 1'b0;
			end else if (rx_hold_req && !rx_hold_done) begin
				rx_hold_left <= RX_HOLD_CYCLES;
				rx_hold_done <= 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !rx_idles();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic wait_drain();
		while (text_bytes.size() != 0 || clean_words.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_drop(logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		drop_ctl = v;
		@(negedge clk);
	endtask

	// random text: words, whitespace runs, line breaks and noise
	task automatic queue_text(int n_items, logic long_runs);
		int cnt;
		int r;
		int len;
		int j;
		cnt = 0;
		while (cnt < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				len = $urandom_range(1, 6);
				for (j = 0; j < len; j++)
					text_bytes.push_back(8'($urandom_range(8'h21, 8'hFF)));
			end else if (r < 75) begin
				len = $urandom_range(1, 4);
				if ($urandom_range(0, 9) == 0)
					len = long_runs ? $urandom_range(60, 70) : $urandom_range(30, 63);
				for (j = 0; j < len; j++)
					text_bytes.push_back($urandom_range(0, 1) ? tblt_pkg::CH_TAB :
						tblt_pkg::CH_SPACE);
			end else if (r < 88) begin
				len = $urandom_range(1, 3);
				for (j = 0; j < len; j++)
					text_bytes.push_back(tblt_pkg::CH_LF);
			end else if (r < 95) begin
				len = 1;
				text_bytes.push_back(8'($urandom_range(0, 31)));
			end else begin
				len = 1;
				text_bytes.push_back(8'($urandom));
			end
			cnt += len;
		end
	endtask

	initial begin
		int j;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty first line, runs flushed by visible bytes, dropped controls
		idle_mode = IDLE_TX_LIGHT;
		text_bytes = '{tblt_pkg::CH_LF, 8'h41, tblt_pkg::CH_SPACE, tblt_pkg::CH_TAB, 8'hFF,
			8'h00, 8'h1F, 8'h7F, 8'h80, tblt_pkg::CH_SPACE, tblt_pkg::CH_LF,
			tblt_pkg::CH_LF, tblt_pkg::CH_SPACE, tblt_pkg::CH_TAB, 8'h01, 8'h42};
		wait_drain();

		// control bytes kept as visible
		write_drop(1'b0);
		text_bytes = '{8'h00, tblt_pkg::CH_SPACE, 8'h1F, tblt_pkg::CH_LF, 8'h05,
			tblt_pkg::CH_TAB, 8'h7E};
		queue_text(25, 1'b0);
		rx_hold_req = 1'b1;
		wait_drain();

		write_drop(1'b1);
		idle_mode = IDLE_TX_HEAVY;
		queue_text(25, 1'b0);
		wait_drain();

		// long runs reach the buffer limit and set the overflow flag
		write_drop(1'b0);
		idle_mode = IDLE_NONE;
		text_bytes.push_back(8'h41);
		for (j = 0; j < LONG_RUN_LEN; j++)
			text_bytes.push_back(j[0] ? tblt_pkg::CH_TAB : tblt_pkg::CH_SPACE);
		text_bytes.push_back(8'h42);
		queue_text(20, 1'b1);
		wait_drain();

		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
